// File: design/sha_pkg.sv
// shared types, constants and round functions for the sha-256 engine
package sha_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_FIN,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_OUT
	} sha_state_t;

	// control from the sequencer to the round datapath
	typedef struct packed {
		logic load;   // working vars take the chaining value
		logic round;  // run one compression round
		logic add;    // fold working vars into the chaining value
		logic init;   // restore the initial hash value
	} core_ctl_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [2:0] LAST_WORD_IDX = 3'd7;
	localparam logic [63:0] BITS_PER_BYTE = 64'd8;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] t;
		t = {x, x} >> n;
		return t[31:0];
	endfunction

	// schedule sigmas
	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
	endfunction

	// round sigmas
	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
	endfunction

endpackage

// File: design/sha_sched.sv
// block buffer and message schedule window, sixteen words that shift each round
module sha_sched
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        wr_en,
	input  logic [5:0]  wr_idx,
	input  logic [7:0]  wr_byte,
	input  logic        shift_en,
	output logic [31:0] w_cur
);

	logic [31:0] win_q [16];
	logic [31:0] w_new;
	logic [4:0]  lane_lsb;

	// big-endian: byte 0 of a word is its top byte
	assign lane_lsb = {~wr_idx[1:0], 3'b000};
	assign w_new = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
	assign w_cur = win_q[0];

	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_new;
		end else if (wr_en) begin
			win_q[wr_idx[5:2]][lane_lsb +: 8] <= wr_byte;
		end
	end

endmodule

// File: design/sha_core.sv
// round datapath: working variables, chaining value and the shared round adder
module sha_core
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  core_ctl_t   ctl,
	input  logic [5:0]  rnd,
	input  logic [31:0] w_cur,
	input  logic [2:0]  rd_idx,
	output logic [31:0] rd_word
);

	logic [31:0] chain_q [8];
	logic [31:0] v_q [8];
	logic [31:0] t1, t2, ch, maj;

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + bsig1(v_q[4]) + ch + ROUND_K[rnd] + w_cur;
	assign t2  = bsig0(v_q[0]) + maj;
	assign rd_word = chain_q[rd_idx];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (ctl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= IV[i];
			end
		end else if (ctl.init) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= IV[i];
			end
		end else if (ctl.add) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

endmodule

// File: design/sha256_hash_engine.sv
// sha-256 engine top level: byte intake, padding sequencer and digest output
//
// The engine hashes a message fed one byte per item and, on the item marked
// last, pads the message, finishes the hash and delivers the eight digest
// words (index 0 = most significant) on the output channel. Each full
// 64-byte block holds in_stall high while it compresses: 64 rounds on the
// single round adder, one round per cycle, then a fold of the result into
// the chaining value (the working variables load in the same cycle the
// block's last byte lands). The last item starts padding, which writes one
// pad or length byte per cycle through the same buffer port while no block
// is compressing, then one or two block compressions and eight output
// items, one per cycle without stall. The engine takes no new item until
// the eighth digest word has gone out, and then starts the next message
// from the initial hash value.
module sha256_hash_engine
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input item channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        last_item,
	// digest channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha_state_t  state_q, state_d;
	sha_state_t  ret_q, ret_d;     // where to go after a compression
	logic [5:0]  fill_q;           // bytes held in the current block
	logic [63:0] bits_q;           // message length in bits, wraps
	logic [5:0]  rnd_q;            // round counter
	logic [2:0]  idx_q;            // digest word being delivered

	logic        in_acc, out_acc;
	logic        buf_wr, wrap;
	logic [7:0]  buf_byte;
	logic [2:0]  len_sel;
	logic [7:0]  len_byte;
	logic [31:0] w_cur;
	core_ctl_t   ctl;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign wrap    = buf_wr && (fill_q == LAST_POS);

	// length bytes go out most significant first at positions 56..63
	assign len_sel  = 3'(3'd7 - fill_q[2:0]);
	assign len_byte = bits_q[{len_sel, 3'b000} +: 8];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (wrap) begin
						state_d = ST_COMP;
					end else if (last_item) begin
						state_d = ST_PAD_MARK;
					end
				end
			end
			ST_COMP: begin
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: state_d = ret_q;
			ST_PAD_MARK: state_d = wrap ? ST_COMP : ST_PAD_ZERO;
			ST_PAD_ZERO: begin
				if (fill_q == LEN_POS) begin
					state_d = ST_PAD_LEN;
				end else if (wrap) begin
					state_d = ST_COMP;
				end
			end
			ST_PAD_LEN: begin
				if (wrap) begin
					state_d = ST_COMP;
				end
			end
			ST_OUT: begin
				if (out_acc && idx_q == LAST_WORD_IDX) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath control
	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		buf_wr    = 1'b0;
		buf_byte  = data_byte;
		ret_d     = ret_q;
		ctl       = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				buf_wr   = in_valid && byte_present;
				ret_d    = last_item ? ST_PAD_MARK : ST_IDLE;
			end
			ST_COMP: ctl.round = 1'b1;
			ST_FIN: ctl.add = 1'b1;
			ST_PAD_MARK: begin
				buf_wr   = 1'b1;
				buf_byte = PAD_BYTE;
				ret_d    = ST_PAD_ZERO;
			end
			ST_PAD_ZERO: begin
				buf_wr   = (fill_q != LEN_POS);
				buf_byte = '0;
				ret_d    = ST_PAD_ZERO;
			end
			ST_PAD_LEN: begin
				buf_wr   = 1'b1;
				buf_byte = len_byte;
				ret_d    = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				ctl.init  = out_acc && (idx_q == LAST_WORD_IDX);
			end
			default: ;
		endcase
		// a full block loads the working vars as its last byte is written
		ctl.load = wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			fill_q  <= '0;
			bits_q  <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (wrap) begin
				ret_q <= ret_d;
			end
			if (buf_wr) begin
				fill_q <= fill_q + 6'd1;
			end
			if (ctl.init) begin
				bits_q <= '0;
			end else if (in_acc && byte_present) begin
				bits_q <= bits_q + BITS_PER_BYTE;
			end
			if (ctl.load) begin
				rnd_q <= '0;
			end else if (ctl.round) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (out_acc) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	sha_sched u_sched (
		.clk      (clk),
		.wr_en    (buf_wr),
		.wr_idx   (fill_q),
		.wr_byte  (buf_byte),
		.shift_en (ctl.round),
		.w_cur    (w_cur)
	);

	sha_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rnd     (rnd_q),
		.w_cur   (w_cur),
		.rd_idx  (idx_q),
		.rd_word (digest_word)
	);

	assign word_index = idx_q;
	assign last_word  = (idx_q == LAST_WORD_IDX);

`ifndef SYNTH
	// digest words are only offered while intake is closed
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("digest offered while input open");

	// rounds advance one per cycle during compression
	a_round_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP && rnd_q != LAST_ROUND) |=> rnd_q == $past(rnd_q) + 6'd1)
		else $error("round counter skipped");

	// length bytes land only in the last eight buffer positions
	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAD_LEN |-> fill_q[5:3] == 3'b111)
		else $error("length byte outside tail of block");

	// after the final digest word the next message starts clean
	a_msg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_word) |=> (bits_q == '0 && fill_q == '0 && state_q == ST_IDLE))
		else $error("engine not cleared after digest");
`endif

endmodule
